// ===== rtl/rrbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ROM/RAM bank controller package
// Field widths, address regions, register indexes and the banking state type.
// ----------------------------------------------------------------------------
package rrbc_pkg;

  localparam int unsigned AddrW    = 15;
  localparam int unsigned DataW    = 8;
  localparam int unsigned RomBankW = 7;
  localparam int unsigned RamBankW = 2;
  localparam int unsigned RomCntW  = 8;
  localparam int unsigned RamCntW  = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  // Thresholds on the number of ROM banks.
  localparam logic [RomCntW-1:0] RomCntSmall = 8'd16;
  localparam logic [RomCntW-1:0] RomCntMid   = 8'd32;
  localparam logic [RomCntW-1:0] RomCntLarge = 8'd64;
  localparam logic [RamCntW-1:0] RamCntBanked = 3'd4;
  localparam logic [3:0]         RamEnKey     = 4'hA;

  localparam logic [RomCntW-1:0] RomCntReset = 8'd2;
  localparam logic [RamCntW-1:0] RamCntReset = 3'd0;

  // Control space regions, selected by the two top address bits.
  typedef enum logic [1:0] {
    RegionRamEnable = 2'd0,
    RegionLowBits   = 2'd1,
    RegionUpperBits = 2'd2,
    RegionMode      = 2'd3
  } region_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRomBankCount = 1'b0,
    CfgRamBankCount = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                ram_en;
    logic                mode;
    logic [RomBankW-1:0] low_bank;
    logic [RomBankW-1:0] high_bank;
    logic [RamBankW-1:0] ram_bank;
    logic [RamBankW-1:0] saved_ram_bank;
  } bank_state_t;

  localparam bank_state_t StateReset = '{
    ram_en:         1'b0,
    mode:           1'b0,
    low_bank:       7'd0,
    high_bank:      7'd1,
    ram_bank:       2'd0,
    saved_ram_bank: 2'd0
  };

endpackage

// ===== rtl/rrbc_wr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Control write channel
// One processor write into the cartridge control space per transfer.
// ----------------------------------------------------------------------------
interface rrbc_wr_if;
  logic                       valid;
  logic                       ready;
  logic [rrbc_pkg::AddrW-1:0] write_address;
  logic [rrbc_pkg::DataW-1:0] write_data;

  modport source (output valid, write_address, write_data, input ready);
  modport sink   (input valid, write_address, write_data, output ready);
endinterface

// ===== rtl/rrbc_map_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapping channel
// Reports the mapped banks and mode flags after each control write.
// ----------------------------------------------------------------------------
interface rrbc_map_if;
  logic                          valid;
  logic                          ready;
  logic [rrbc_pkg::RomBankW-1:0] low_window_bank;
  logic [rrbc_pkg::RomBankW-1:0] high_window_bank;
  logic [rrbc_pkg::RamBankW-1:0] ram_bank;
  logic                          ram_enabled;
  logic                          advanced_mode;

  modport source (output valid, low_window_bank, high_window_bank, ram_bank,
                  ram_enabled, advanced_mode, input ready);
  modport sink   (input valid, low_window_bank, high_window_bank, ram_bank,
                  ram_enabled, advanced_mode, output ready);
endinterface

// ===== rtl/rrbc_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Writes one configuration register per transfer.
// ----------------------------------------------------------------------------
interface rrbc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rrbc_pkg::CfgIdxW-1:0]  index;
  logic [rrbc_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rrbc_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank state update
// Applies one control write to the banking state.
// ----------------------------------------------------------------------------
module rrbc_update (
  input  logic [rrbc_pkg::RomCntW-1:0] rom_cnt_i,
  input  logic [rrbc_pkg::RamCntW-1:0] ram_cnt_i,
  input  logic [rrbc_pkg::AddrW-1:0]   addr_i,
  input  logic [rrbc_pkg::DataW-1:0]   data_i,
  input  rrbc_pkg::bank_state_t        st_i,
  output rrbc_pkg::bank_state_t        st_o
);
  import rrbc_pkg::*;

  region_e             region;
  logic [RomCntW-1:0]  rom_mask;
  logic                rom_small;
  logic                rom_mid_up;
  logic                rom_large;
  logic                rom_huge;
  logic                ram_banked;
  logic [4:0]          low_bits;
  logic [1:0]          upper;
  logic [RomBankW-1:0] new_high;
  logic [1:0]          held_upper;

  assign region     = region_e'(addr_i[AddrW-1 -: 2]);
  assign rom_mask   = rom_cnt_i - 8'd1;
  assign rom_small  = (rom_cnt_i <= RomCntSmall);
  assign rom_mid_up = (rom_cnt_i > RomCntMid);
  assign rom_large  = (rom_cnt_i >= RomCntLarge);
  assign rom_huge   = (rom_cnt_i > RomCntLarge);
  assign ram_banked = (ram_cnt_i == RamCntBanked);
  assign held_upper = st_i.high_bank[6:5];

  always_comb begin
    // A zero in the low bank bits selects bank 1; small ROMs then mask it.
    low_bits = (data_i[4:0] == 5'd0) ? 5'd1 : data_i[4:0];
    if (rom_small) begin
      low_bits = low_bits & rom_mask[4:0];
    end
    upper    = rom_huge ? data_i[1:0] : {1'b0, data_i[0]};
    new_high = {upper, st_i.high_bank[4:0]};
  end

  always_comb begin
    st_o = st_i;
    case (region)
      RegionRamEnable: begin
        st_o.ram_en = (data_i[3:0] == RamEnKey);
      end
      RegionLowBits: begin
        st_o.high_bank = {(rom_mid_up ? held_upper : 2'b00), low_bits};
      end
      RegionUpperBits: begin
        if (rom_large) begin
          if (new_high != st_i.high_bank) begin
            st_o.high_bank = new_high;
            if (st_i.mode) begin
              st_o.low_bank = {upper, 5'd0};
            end
          end
        end else if (ram_banked) begin
          if (st_i.mode) begin
            st_o.ram_bank = data_i[1:0];
          end else begin
            st_o.saved_ram_bank = data_i[1:0];
          end
        end
      end
      RegionMode: begin
        if (data_i[0] != st_i.mode) begin
          st_o.mode = data_i[0];
          if (data_i[0]) begin
            if (rom_large) begin
              if (held_upper != 2'b00) begin
                st_o.low_bank = {held_upper, 5'd0};
              end
            end else if (ram_banked && (st_i.saved_ram_bank != 2'b00)) begin
              st_o.ram_bank = st_i.saved_ram_bank;
            end
          end else begin
            if (rom_large) begin
              if (held_upper != 2'b00) begin
                st_o.low_bank = '0;
              end
            end else if (ram_banked) begin
              st_o.saved_ram_bank = st_i.ram_bank;
              st_o.ram_bank       = '0;
            end
          end
        end
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

endmodule

// ===== rtl/rom_ram_bank_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ROM/RAM bank controller core
// Tracks RAM enable, banking mode and the mapped ROM and RAM banks, and
// reports the mapping after every control write.
// ----------------------------------------------------------------------------
//  channel | modport | direction | carries
//  wr_i    | sink    | in        | write_address, write_data
//  map_o   | source  | out       | low/high window bank, ram bank, flags
//  cfg_i   | sink    | in        | register index, data (always ready)
//
// A write is captured in an input register and, once the result register is free
// or being read, applied to the bank state while its mapping is loaded into the
// result register. One write per cycle sustained while the result is not stalled.
// A stalled result holds both stages; a free input stage still takes a write.
// Reset sets the bank state and configuration to their defaults at once.
// ----------------------------------------------------------------------------
module rom_ram_bank_controller_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrbc_wr_if.sink    wr_i,
  rrbc_map_if.source map_o,
  rrbc_cfg_if.sink   cfg_i
);
  import rrbc_pkg::*;

  logic               in_v_q;
  logic [AddrW-1:0]   in_addr_q;
  logic [DataW-1:0]   in_data_q;
  logic               res_v_q;
  bank_state_t        res_q;
  bank_state_t        st_q;
  bank_state_t        st_d;
  logic [RomCntW-1:0] rom_cnt_q;
  logic [RamCntW-1:0] ram_cnt_q;
  logic               adv;
  logic               in_take;

  assign adv     = in_v_q && (!res_v_q || map_o.ready);
  assign in_take = wr_i.valid && wr_i.ready;

  assign wr_i.ready  = !in_v_q || adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_cnt_q <= RomCntReset;
      ram_cnt_q <= RamCntReset;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgRomBankCount: rom_cnt_q <= cfg_i.data;
        CfgRamBankCount: ram_cnt_q <= cfg_i.data[RamCntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (wr_i.ready) begin
      in_v_q <= wr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_addr_q <= wr_i.write_address;
      in_data_q <= wr_i.write_data;
    end
  end

  rrbc_update u_update (
    .rom_cnt_i (rom_cnt_q),
    .ram_cnt_i (ram_cnt_q),
    .addr_i    (in_addr_q),
    .data_i    (in_data_q),
    .st_i      (st_q),
    .st_o      (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StateReset;
      res_v_q <= 1'b0;
    end else begin
      if (adv) begin
        st_q <= st_d;
      end
      if (adv) begin
        res_v_q <= 1'b1;
      end else if (map_o.ready) begin
        res_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= st_d;
    end
  end

  assign map_o.valid            = res_v_q;
  assign map_o.low_window_bank  = res_q.low_bank;
  assign map_o.high_window_bank = res_q.high_bank;
  assign map_o.ram_bank         = res_q.ram_bank;
  assign map_o.ram_enabled      = res_q.ram_en;
  assign map_o.advanced_mode    = res_q.mode;

  // The shown mapping always tracks the live bank state.
  a_res_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |-> (res_q == st_q))
    else $error("result register differs from bank state");

  // The low window only ever maps a multiple of 32.
  a_low_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.low_bank[4:0] == 5'd0)
    else $error("low window bank not aligned");

  // A write that moves on always leaves a result behind.
  a_adv_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> res_v_q)
    else $error("write applied without a result");

  // A held write in the input stage is not dropped.
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !adv) |=> (in_v_q && $stable(in_addr_q) && $stable(in_data_q)))
    else $error("pending write lost");

endmodule
